// ----- design/idl_pkg.sv -----
// Shared constants and types for the indexed insert/delete list.
// Used by idl_cell and indexed_insert_delete_list_core; depends on nothing.
package idl_pkg;

   localparam int CAPACITY   = 128;
   localparam int WORD_W     = 32;
   localparam int POS_W      = 8;
   localparam int COUNT_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = $clog2(CAPACITY + 1);
   localparam int CMP_W      = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam int GROUP_SIZE = 16;
   localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // Operation broadcast to every cell of the row.
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [CMP_W-1:0]  pos;
      logic [WORD_W-1:0] value;
   } idl_op_type;

endpackage

// ----- design/indexed_insert_delete_list_core.sv -----
// Top level of the indexed insert/delete list: request decode, length, row of cells.
// Depends on idl_pkg and idl_cell.
//
// The block keeps an ordered list of up to CAPACITY signed words in a row of cells.
// A request on the req_ channel either inserts req_tdata's value at a position,
// moving later entries up one cell, or deletes the entry at a position, moving
// later entries down one cell. All cells move in the same cycle.
// Each request gives exactly one result on the rsp_ channel: a status in
// rsp_tuser, and the removed word and the new length in rsp_tdata.
// A request's removed word is read out of the row through a registered two-level OR tree
// (groups of sixteen cells, then across the groups): the group results are registered,
// and the OR across the groups feeds the output register. A new request is taken only
// once the last one has moved its result into the output register.
// The result waits in an output register while the receiver stalls, and one more
// request is taken meanwhile; it then holds until the output register frees.
// Reset empties the list; cell contents are not cleared and are never read
// beyond the current length.
module indexed_insert_delete_list_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [39:0]                    req_tdata,  // position[7:0], value[39:8]
   input  logic                           req_tuser,  // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,  // removed[31:0], count[39:32]
   output logic [idl_pkg::STATUS_W-1:0]   rsp_tuser   // status
);
   import idl_pkg::*;

   typedef enum logic {S_IDLE, S_DONE} state_type;

   state_type          state_ff;
   logic [LEN_W-1:0]   length_ff;
   logic [LEN_W-1:0]   length_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [COUNT_W-1:0] count_ff;
   logic [WORD_W-1:0]  group_ff [GROUPS];
   logic [WORD_W-1:0]  group_in [GROUPS];
   logic [WORD_W-1:0]  removed_in;
   logic               rsp_tvalid_ff;
   logic [WORD_W-1:0]  rsp_removed_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic               accept;
   logic               out_free;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   len_ext;
   logic [CMP_W-1:0]   len_next_ext;
   logic               ins_ok;
   logic               del_ok;
   idl_op_type         op;

   logic [WORD_W-1:0]  cell_data [CAPACITY];
   logic [WORD_W-1:0]  cell_pick [CAPACITY];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      pos_ext   = CMP_W'(req_tdata[POS_W-1:0]);
      len_ext   = CMP_W'(length_ff);
      ins_ok    = 1'b0;
      del_ok    = 1'b0;
      status_in = ST_RANGE;
      if (req_tuser == MODE_INSERT) begin
         if (pos_ext > len_ext) begin
            status_in = ST_RANGE;
         end else if (len_ext >= CMP_W'(CAPACITY)) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_DONE;
            ins_ok    = 1'b1;
         end
      end else begin
         if (pos_ext >= len_ext) begin
            status_in = ST_RANGE;
         end else begin
            status_in = ST_DONE;
            del_ok    = 1'b1;
         end
      end
      length_in = length_ff;
      if (ins_ok) begin
         length_in = length_ff + LEN_W'(1);
      end else if (del_ok) begin
         length_in = length_ff - LEN_W'(1);
      end
      len_next_ext = CMP_W'(length_in);
      op.ins   = accept && ins_ok;
      op.del   = accept && del_ok;
      op.pos   = pos_ext;
      op.value = req_tdata[POS_W +: WORD_W];
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [WORD_W-1:0] left_data;
         logic [WORD_W-1:0] right_data;
         if (gi == 0) begin : g_first
            assign left_data = '0;
         end else begin : g_mid_left
            assign left_data = cell_data[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_mid_right
            assign right_data = cell_data[gi+1];
         end
         idl_cell u_cell (
            .clock      (clock),
            .op         (op),
            .index      (CMP_W'(gi)),
            .left_data  (left_data),
            .right_data (right_data),
            .data_out   (cell_data[gi]),
            .pick_out   (cell_pick[gi])
         );
      end
   endgenerate

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               group_in[g] = group_in[g] | cell_pick[g * GROUP_SIZE + k];
            end
         end
         if (!del_ok) begin
            group_in[g] = '0;
         end
      end
      removed_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         removed_in = removed_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         length_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  length_ff <= length_in;
                  status_ff <= status_in;
                  count_ff  <= len_next_ext[COUNT_W-1:0];
                  group_ff  <= group_in;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_removed_ff <= removed_in;
                  rsp_count_ff   <= count_ff;
                  rsp_status_ff  <= status_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_removed_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(length_ff) <= CMP_W'(CAPACITY))
      else $error("List length exceeds capacity.");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("A second request was taken before the first finished.");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && ins_ok) |=> (length_ff == $past(length_ff) + LEN_W'(1)))
      else $error("A successful insert did not grow the list by one.");

   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_status_ff != ST_DONE)) |-> (rsp_removed_ff == '0))
      else $error("A refused request reported a removed word.");

endmodule

// ----- design/idl_cell.sv -----
// One storage cell of the list row: holds a single entry and trades it with its neighbors.
// Depends on idl_pkg.
module idl_cell (
   input  logic                      clock,
   input  idl_pkg::idl_op_type       op,
   input  logic [idl_pkg::CMP_W-1:0] index,
   input  logic [idl_pkg::WORD_W-1:0] left_data,
   input  logic [idl_pkg::WORD_W-1:0] right_data,
   output logic [idl_pkg::WORD_W-1:0] data_out,
   output logic [idl_pkg::WORD_W-1:0] pick_out
);
   import idl_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;
   logic              at_pos;
   logic              past_pos;

   always_comb begin
      at_pos   = (index == op.pos);
      past_pos = (index > op.pos);
      data_in  = data_ff;
      if (op.ins) begin
         if (at_pos) begin
            data_in = op.value;
         end else if (past_pos) begin
            data_in = left_data;
         end
      end else if (op.del && (at_pos || past_pos)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign pick_out = at_pos ? data_ff : '0;

endmodule

// ----- bench/indexed_insert_delete_list_core_tb.sv -----
// Self-checking bench for indexed_insert_delete_list_core: directed and random
// insert/delete requests, a running model of the list, and per-field result checks.
// Depends on idl_pkg and the design files under design.
module indexed_insert_delete_list_core_tb;
   import idl_pkg::*;

   typedef struct {
      logic        mode;
      logic [7:0]  position;
      logic [31:0] value;
      int          idle_pct;
      int          stall_pct;
      bit          wait_idle;
   } list_request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [31:0]         removed;
      logic [7:0]          count;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // position[7:0], value[39:8]
   logic        req_tuser = 1'b0;  // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;  // removed[31:0], count[39:32]
   logic [STATUS_W-1:0] rsp_tuser;  // status

   list_request_type pending[$];
   list_result_type  expected_results[$];
   logic [31:0]   list_words[CAPACITY];
   int            list_len = 0;
   int            plan_len = 0;
   int            cur_idle = 0;
   int            cur_stall = 0;
   bit            cur_wait = 1'b0;
   int            tx_idle_pct = 0;
   int            rx_stall_pct = 0;
   logic          req_fired = 1'b0;
   int            fail_count = 0;
   int            request_total = 0;
   int            deepest_len = 0;
   int            status_seen[3] = '{0, 0, 0};

   indexed_insert_delete_list_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   task automatic predict_list_request(input logic mode, input logic [7:0] pos,
                                       input logic [31:0] word);
      list_result_type res;
      int i;
      res.status = ST_DONE;
      res.removed = '0;
      if (mode == MODE_INSERT) begin
         if (pos > list_len) begin
            res.status = ST_RANGE;
         end else if (list_len >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            for (i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
            list_words[pos] = word;
            list_len++;
         end
      end else begin
         if (pos >= list_len) begin
            res.status = ST_RANGE;
         end else begin
            res.removed = list_words[pos];
            for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
            list_len--;
         end
      end
      res.count = 8'(list_len);
      if (list_len > deepest_len) deepest_len = list_len;
      expected_results.push_back(res);
   endtask

   always @(posedge clock) begin : result_monitor
      list_result_type want;
      req_fired <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: status %0d removed %0h count %0d",
                      rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32]);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[31:0] !== want.removed) begin
                  $error("removed: expected %0h, got %0h", want.removed, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[39:32] !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_tdata[39:32]);
                  fail_count++;
               end
               status_seen[want.status]++;
            end
         end
         if (req_tvalid && req_tready) begin
            predict_list_request(req_tuser, req_tdata[7:0], req_tdata[39:8]);
            request_total++;
         end
      end
   end

   always @(negedge clock) begin : request_driver
      list_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         if (!req_tvalid || req_fired) begin
            if (pending.size() != 0) begin
               tx_idle_pct = pending[0].idle_pct;
               rx_stall_pct = pending[0].stall_pct;
            end
            if (pending.size() == 0
                || (pending[0].wait_idle && expected_results.size() != 0)
                || $urandom_range(99) < tx_idle_pct) begin
               req_tvalid <= 1'b0;
            end else begin
               item = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item.mode;
               req_tdata <= {item.value, item.position};
            end
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(11))
         0: pick_word = 32'h8000_0000;
         1: pick_word = 32'h7FFF_FFFF;
         2: pick_word = 32'h0000_0000;
         3: pick_word = 32'hFFFF_FFFF;
         default: pick_word = $urandom();
      endcase
   endfunction

   // The queue is filled ahead of time, so the list length is tracked here too;
   // it depends only on mode and position, never on the words.
   task automatic push_request(input logic mode, input int pos, input logic [31:0] word);
      list_request_type item;
      item.mode = mode;
      item.position = 8'(pos);
      item.value = word;
      item.idle_pct = cur_idle;
      item.stall_pct = cur_stall;
      item.wait_idle = cur_wait;
      cur_wait = 1'b0;
      pending.push_back(item);
      if (mode == MODE_INSERT && pos <= plan_len && plan_len < CAPACITY) plan_len++;
      if (mode == MODE_DELETE && pos < plan_len) plan_len--;
   endtask

   function automatic int pick_position(input int top);
      case ($urandom_range(3))
         0: pick_position = 0;
         1: pick_position = top;
         default: pick_position = $urandom_range(top, 0);
      endcase
   endfunction

   task automatic step_list(input bit grow);
      if (grow) begin
         push_request(MODE_INSERT, pick_position(plan_len), pick_word());
      end else if (plan_len > 0) begin
         push_request(MODE_DELETE, pick_position(plan_len - 1), pick_word());
      end else begin
         push_request(MODE_DELETE, 0, pick_word());
      end
   endtask

   task automatic push_broken();
      if ($urandom_range(1) == 0) begin
         if (plan_len < CAPACITY) begin
            push_request(MODE_INSERT, $urandom_range(CAPACITY, plan_len + 1), pick_word());
         end else begin
            push_request(MODE_INSERT, $urandom_range(CAPACITY, 0), pick_word());
         end
      end else begin
         push_request(MODE_DELETE, $urandom_range(CAPACITY, plan_len), pick_word());
      end
   endtask

   task automatic run_toward(input int target);
      int r;
      while (plan_len != target) begin
         r = $urandom_range(99);
         if (r < 78) step_list(plan_len < target);
         else if (r < 90) step_list(plan_len > target);
         else push_broken();
      end
      if (target == CAPACITY) repeat (3) step_list(1'b1);
      if (target == 0) repeat (2) step_list(1'b0);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int start;
      cur_idle = idle_pct;
      cur_stall = stall_pct;
      cur_wait = 1'b1;
      start = pending.size();
      run_toward(CAPACITY);
      run_toward(0);
      while (pending.size() - start < 370) run_toward($urandom_range(CAPACITY, 0));
   endtask

   initial begin
      push_request(MODE_DELETE, 0, 32'h0000_0001);
      push_request(MODE_INSERT, 1, 32'h0000_0005);
      push_request(MODE_INSERT, 0, 32'h8000_0000);
      push_request(MODE_INSERT, 1, 32'h7FFF_FFFF);
      push_request(MODE_INSERT, 0, 32'hFFFF_FFFF);
      push_request(MODE_INSERT, 2, 32'h0000_0000);
      push_request(MODE_INSERT, CAPACITY, 32'h1234_5678);
      push_request(MODE_DELETE, CAPACITY, 32'h0000_0000);
      push_request(MODE_DELETE, 4, 32'h0000_0000);
      push_request(MODE_INSERT, 5, 32'hA5A5_A5A5);
      push_request(MODE_DELETE, 3, 32'h0000_0000);
      push_request(MODE_DELETE, 1, 32'h0000_0000);
      push_request(MODE_DELETE, 0, 32'hFFFF_FFFF);
      push_request(MODE_DELETE, 0, 32'h0000_0000);
      push_request(MODE_DELETE, 0, 32'h0000_0000);
      run_phase(0, 0);
      run_phase(74, 0);
      run_phase(0, 74);
      run_phase(29, 29);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         fail_count++;
      end

      $display("Ran %0d requests: %0d done, %0d out of range, %0d refused as full.",
               request_total, status_seen[ST_DONE], status_seen[ST_RANGE],
               status_seen[ST_FULL]);
      $display("The list reached %0d entries and was emptied again under four idle mixes.",
               deepest_len);
      if (fail_count == 0) begin
         $display("indexed_insert_delete_list_core_tb OK");
      end else begin
         $display("indexed_insert_delete_list_core_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("indexed_insert_delete_list_core_tb NOT OK");
      $finish;
   end

endmodule
